// ----- design/fsa_pkg.sv -----
package fsa_pkg;

  // Slot indices travel on the ports as four bits.
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned SLOT_RANGE = 1 << SLOT_W;
  localparam int unsigned POOL_COUNT = 3;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    POOL_SQUARE  = 2'd0,
    POOL_VECTOR  = 2'd1,
    POOL_FORM    = 2'd2,
    POOL_INVALID = 2'd3
  } pool_id_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_UNKNOWN_POOL  = 3'd1,
    ST_POOL_EMPTY    = 3'd2,
    ST_OUT_OF_RANGE  = 3'd3,
    ST_NOT_ALLOCATED = 3'd4
  } status_t;

  // One free-list entry: the low bits of the slot index and a flag for
  // indices that do not fit the port field (never marked, never freed).
  typedef struct packed {
    logic              hi;
    logic [SLOT_W-1:0] idx;
  } entry_t;

  // Shift control shared by every cell of one stack.
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

  // Request from the top level to one pool.
  typedef struct packed {
    cell_ctl_t         ctl;
    logic [SLOT_W-1:0] slot;
  } pool_req_t;

  // What one pool reports about the current request.
  typedef struct packed {
    logic   empty;
    logic   in_range;
    logic   marked;
    entry_t top;
  } pool_stat_t;

endpackage

// ----- design/fixed_pool_slot_allocator.sv -----
// Allocator for three pools of fixed-size slots: square matrices, column
// vectors and quadratic forms. Each pool keeps a last-in-first-out list of
// free slot indices, held as a row of shift cells with the top at cell 0.
//
// Requests arrive on the in_ stream, one item per request. An allocate pops
// the top free index of the named pool and returns it in granted_slot; a
// free checks the slot's allocated mark, clears it and pushes the index
// back. Every request yields exactly one result item on the out_ stream
// with a status code; failed requests change no state.
//
// The result of an accepted item is registered and presented in the cycle
// after it is accepted. Throughput is one item per cycle while the
// receiver takes each result; the cell row shifts once per push or pop.
//
// The result sits in an output register. When the receiver stalls, that
// register holds its item and in_tready drops until it is taken; a new
// item is taken in the same cycle the old result leaves.
//
// Reset (rst_n low, synchronous) refills every pool, clears all allocated
// marks and empties the output register; no clearing pass is needed.
module fixed_pool_slot_allocator #(
  parameter int unsigned SQUARE_POOL_SLOTS = 16,
  parameter int unsigned VECTOR_POOL_SLOTS = 16,
  parameter int unsigned FORM_POOL_SLOTS   = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  // [0] opcode, [2:1] pool_type, [6:3] slot_index, [7] clear_request
  input  logic [7:0] in_tdata,
  output logic       out_tvalid,
  input  logic       out_tready,
  // [3:0] granted_slot, [6:4] status, [7] clear_slot
  output logic [7:0] out_tdata
);
  import fsa_pkg::*;

  localparam int unsigned POOL_SLOTS [POOL_COUNT] =
    '{SQUARE_POOL_SLOTS, VECTOR_POOL_SLOTS, FORM_POOL_SLOTS};

  // Request fields.
  op_t               op;
  pool_id_t          pool;
  logic [SLOT_W-1:0] slot;
  logic              clr_req;
  logic              accept;

  pool_req_t  reqs  [POOL_COUNT];
  pool_stat_t stats [POOL_COUNT];
  pool_stat_t sel;

  // Result of the current request.
  logic [SLOT_W-1:0] granted;
  status_t           status;
  logic              clr_out;

  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [7:0] out_data_r;
  logic [7:0] out_data_nxt;

  assign op      = op_t'(in_tdata[0]);
  assign pool    = pool_id_t'(in_tdata[2:1]);
  assign slot    = in_tdata[6:3];
  assign clr_req = in_tdata[7];

  // The output register frees up in the cycle its item is taken.
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  for (genvar p = 0; p < POOL_COUNT; p++) begin : g_pool
    logic hit;
    assign hit = accept && (pool == pool_id_t'(p));

    assign reqs[p].slot     = slot;
    assign reqs[p].ctl.pop  = hit && (op == OP_ALLOC) && !stats[p].empty;
    assign reqs[p].ctl.push = hit && (op == OP_FREE) && stats[p].in_range
                              && stats[p].marked;

    fsa_pool #(.SLOTS(POOL_SLOTS[p])) u_pool (
      .clk   (clk),
      .rst_n (rst_n),
      .req   (reqs[p]),
      .stat  (stats[p])
    );
  end

  always_comb begin
    case (pool)
      POOL_SQUARE: sel = stats[0];
      POOL_VECTOR: sel = stats[1];
      POOL_FORM:   sel = stats[2];
      default:     sel = '0;
    endcase
  end

  // Decide the result; failed requests grant nothing and never ask for a
  // zero fill.
  always_comb begin
    granted = '0;
    status  = ST_OK;
    clr_out = 1'b0;
    if (pool == POOL_INVALID) begin
      status = ST_UNKNOWN_POOL;
    end else if (op == OP_ALLOC) begin
      if (sel.empty) begin
        status = ST_POOL_EMPTY;
      end else begin
        granted = sel.top.idx;
        clr_out = clr_req;
      end
    end else begin
      if (!sel.in_range) begin
        status = ST_OUT_OF_RANGE;
      end else if (!sel.marked) begin
        status = ST_NOT_ALLOCATED;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {clr_out, status, granted};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- design/fsa_cell.sv -----
module fsa_cell #(
  parameter fsa_pkg::entry_t INIT = '0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fsa_pkg::cell_ctl_t ctl,
  input  fsa_pkg::entry_t    above_in,
  input  fsa_pkg::entry_t    below_in,
  output fsa_pkg::entry_t    value
);
  import fsa_pkg::*;

  entry_t value_r;
  entry_t value_nxt;

  // A push moves every entry one place away from the top, a pop one place
  // toward it.
  always_comb begin
    value_nxt = value_r;
    if (ctl.push) begin
      value_nxt = above_in;
    end else if (ctl.pop) begin
      value_nxt = below_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= INIT;
    end else begin
      value_r <= value_nxt;
    end
  end

  assign value = value_r;

endmodule

// ----- design/fsa_pool.sv -----
module fsa_pool #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fsa_pkg::pool_req_t  req,
  output fsa_pkg::pool_stat_t stat
);
  import fsa_pkg::*;

  localparam int unsigned CW = $clog2(SLOTS + 1);

  entry_t                chain [SLOTS];
  entry_t                push_entry;
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;
  logic [SLOT_RANGE-1:0] marks_r;
  logic [SLOT_RANGE-1:0] marks_nxt;

  assign push_entry = '{hi: 1'b0, idx: req.slot};

  // Cell 0 is the top of the stack. Cell k resets to index SLOTS-1-k, so
  // the whole pool is free and the highest index is on top.
  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    localparam int unsigned VAL = SLOTS - 1 - k;
    localparam entry_t INIT_E = '{hi: (VAL >= SLOT_RANGE), idx: SLOT_W'(VAL)};
    entry_t above;
    entry_t below;

    if (k == 0) begin : g_top
      assign above = push_entry;
    end else begin : g_mid
      assign above = chain[k-1];
    end
    if (k == SLOTS - 1) begin : g_bottom
      assign below = '0;
    end else begin : g_inner
      assign below = chain[k+1];
    end

    fsa_cell #(.INIT(INIT_E)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (req.ctl),
      .above_in (above),
      .below_in (below),
      .value    (chain[k])
    );
  end

  always_comb begin
    count_nxt = count_r;
    marks_nxt = marks_r;
    if (req.ctl.pop) begin
      count_nxt = count_r - CW'(1);
      if (!chain[0].hi) begin
        marks_nxt[chain[0].idx] = 1'b1;
      end
    end else if (req.ctl.push) begin
      count_nxt = count_r + CW'(1);
      marks_nxt[req.slot] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CW'(SLOTS);
      marks_r <= '0;
    end else begin
      count_r <= count_nxt;
      marks_r <= marks_nxt;
    end
  end

  assign stat.empty    = (count_r == '0);
  assign stat.in_range = (SLOTS >= SLOT_RANGE) ? 1'b1 : (req.slot < SLOT_W'(SLOTS));
  assign stat.marked   = marks_r[req.slot];
  assign stat.top      = chain[0];

endmodule

// ----- design/fsa_checker.sv -----
module fsa_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);
  import fsa_pkg::*;

  // A stalled result stays on the bus unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Every accepted item yields a result in the next cycle.
  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted item produced no result");

  // An unknown pool is reported as such.
  a_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata[2:1] == POOL_INVALID)
    |=> out_tdata[6:4] == ST_UNKNOWN_POOL)
    else $error("unknown pool not reported");

  // A failed request grants no slot and asks for no zero fill.
  a_fail_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[6:4] != ST_OK) |-> out_tdata[3:0] == '0 && !out_tdata[7])
    else $error("failed request carries a grant");

  // Only the five defined status codes appear.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[6:4] <= ST_NOT_ALLOCATED)
    else $error("undefined status code");

endmodule

bind fixed_pool_slot_allocator fsa_checker u_fsa_checker (.*);
